// ===== design/mbns_pkg.sv =====
// ---------------------------------------------------------------------------
// Note sequencer package
// Shared types and constants for the song player, its divider and its testbench.
// ---------------------------------------------------------------------------
package mbns_pkg;

  localparam int unsigned SongBytesDef = 65536;
  localparam int unsigned LoopSlots = 8;
  localparam int unsigned LengthSlots = 16;
  localparam logic [15:0] StepLimitRst = 16'd4096;
  localparam logic [7:0] TempoRst = 8'd120;
  localparam logic [9:0] InstrumentRst = 10'd2;
  localparam logic [3:0] OctaveRst = 4'd2;
  localparam logic [7:0] NoteBase = 8'h30;
  localparam logic [7:0] OctaveBase = 8'h20;
  localparam logic [7:0] LengthBase = 8'h10;
  localparam logic [7:0] LoopBase = 8'h08;
  localparam logic [7:0] InstBase = 8'h04;
  localparam logic [7:0] DirTempo = 8'h03;
  localparam logic [7:0] DirSustain = 8'h02;
  localparam logic [7:0] DirVolume = 8'h01;
  localparam logic [7:0] DirSweep = 8'h00;
  localparam logic [11:0] MsPerTickNum = 12'd1500;

  typedef enum logic [1:0] {
    ModeLoad  = 2'd0,
    ModeStart = 2'd1,
    ModeFetch = 2'd2,
    ModeNone  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ErrNone   = 2'd0,
    ErrSteps  = 2'd1,
    ErrTempo  = 2'd2,
    ErrUnused = 2'd3
  } err_e;

  typedef enum logic [3:0] {
    StIdle,
    StFetch,
    StDecode,
    StOperand,
    StTie1,
    StTie2,
    StDiv,
    StAdd,
    StOut
  } state_e;

  // Division request and answer between the sequencer and the divider.
  typedef struct packed {
    logic        start;
    logic [19:0] dividend;
    logic [7:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [19:0] quotient;
  } div_rsp_t;

endpackage

// ===== design/mbns_ram.sv =====
// ---------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, registered read data.
// ---------------------------------------------------------------------------
module mbns_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== design/mbns_div.sv =====
// ---------------------------------------------------------------------------
// Restoring divider
// Divides a 20-bit dividend by an 8-bit divisor, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module mbns_div
  import mbns_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [19:0] quo_q, quo_d;
  logic [8:0]  rem_q, rem_d;
  logic [7:0]  dvs_q, dvs_d;
  logic [8:0]  trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q[7:0], quo_q[19]};
    rsp_o.done = 1'b0;
    rsp_o.quotient = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 5'd0;
      quo_d  = req_i.dividend;
      rem_d  = 9'd0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[18:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[18:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd19) begin
        busy_d = 1'b0;
      end
    end else begin
      rsp_o.done = (cnt_q == 5'd20);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= (!busy_d && cnt_q == 5'd20) ? 5'd0 : cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

endmodule

// ===== design/music_bytecode_note_sequencer.sv =====
// ---------------------------------------------------------------------------
// Music bytecode note sequencer
// Song memory with a directive interpreter that returns one note per fetch.
// ---------------------------------------------------------------------------
// A load beat writes one song byte and a start beat resets the player. A
// fetch beat walks directive bytes one memory read at a time, and the
// divider works out the length of each note met, unless the tempo is zero,
// which ends the fetch with an error. A finished note waits in an output
// register, so the block takes new beats while it waits; a second note
// waits in the sequencer until the first is taken.
module music_bytecode_note_sequencer
  import mbns_pkg::*;
#(
  parameter int unsigned SongBytes = SongBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  pitch_o,
  output logic [7:0]  note_volume_o,
  output logic [9:0]  note_instrument_o,
  output logic [7:0]  note_sustain_o,
  output logic [7:0]  note_sweep_o,
  output logic [31:0] length_ms_o,
  output logic [1:0]  error_o
);

  localparam int unsigned AddrW = $clog2(SongBytes);

  state_e st_q, st_d;
  logic [15:0] limit_q;
  logic [15:0] pos_q, pos_d, steps_q, steps_d;
  logic [15:0] tgt_q [LoopSlots];
  logic [7:0]  cnt_q [LoopSlots];
  logic [7:0]  ltab_q [LengthSlots];
  logic [7:0]  vol_q, sus_q, tempo_q, swp_q, vol_d, sus_d, tempo_d, swp_d;
  logic [3:0]  oct_q, oct_d;
  logic [7:0]  dir_q, dir_d;
  logic        tie_q, tie_d, lvl_q, lvl_d, wait_q, wait_d;
  logic [31:0] acc_q, acc_d;
  logic [7:0]  pitch_q, pitch_d, ovol_q, ovol_d, osus_q, osus_d, oswp_q, oswp_d;
  logic [9:0]  oinst_q, oinst_d;
  logic [1:0]  err_q, err_d;
  logic        mem_we;
  logic [15:0] mem_addr;
  logic [15:0] rd_addr;
  logic [7:0]  rdata;
  logic        in_acc, start_def;
  logic        ltab_we, tgt_we, cnt_we;
  logic [7:0]  cnt_new;
  logic [2:0]  slot;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic [32:0] sum;
  logic        res_load;
  logic        rvalid_q;
  logic [7:0]  rpitch_q, rvol_q, rsus_q, rswp_q;
  logic [9:0]  rinst_q;
  logic [31:0] rlen_q;
  logic [1:0]  rerr_q;

  assign in_acc = in_valid_i && in_ready_o;
  assign in_ready_o = (st_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign slot = dir_q[2:0];
  assign sum = {1'b0, acc_q} + {13'd0, drsp.quotient};
  assign res_load = (st_q == StOut) && (!rvalid_q || out_ready_i);

  // The second tie byte sits one address ahead; its address goes out in StTie1.
  assign rd_addr = (st_q == StTie1) ? pos_q + 16'd1 : pos_q;

  mbns_ram #(.Width(8), .Depth(SongBytes)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr[AddrW-1:0]),
    .wdata_i (data_i),
    .rdata_o (rdata)
  );

  mbns_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  // Memory port: the address in the issue cycle, data valid in the cycle after.
  always_comb begin
    mem_we = in_acc && (mode_e'(mode_i) == ModeLoad);
    mem_addr = mem_we ? address_i : rd_addr;
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: begin
        if (in_acc && mode_e'(mode_i) == ModeFetch) begin
          st_d = StFetch;
        end
      end
      StFetch: begin
        if (steps_q >= limit_q) begin
          st_d = StOut;
        end else if (wait_q) begin
          st_d = StDecode;
        end
      end
      StDecode: begin
        if (dir_q >= NoteBase) begin
          st_d = (tempo_q == 8'd0) ? StOut : StDiv;
        end else if (dir_q >= OctaveBase || (dir_q >= InstBase && dir_q < LoopBase)) begin
          st_d = StFetch;
        end else if (wait_q) begin
          st_d = StOperand;
        end
      end
      StOperand: st_d = StFetch;
      StDiv: if (drsp.done) st_d = StAdd;
      StAdd: if (wait_q) st_d = StTie1;
      StTie1: st_d = StTie2;
      StTie2: begin
        if (dir_q == DirTempo && rdata == 8'd0) begin
          st_d = StFetch;
        end else if (lvl_q) begin
          st_d = StOut;
        end else begin
          st_d = StFetch;
        end
      end
      StOut: if (!rvalid_q || out_ready_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_comb begin
    pos_d = pos_q; steps_d = steps_q; dir_d = dir_q; wait_d = 1'b0;
    vol_d = vol_q; sus_d = sus_q; tempo_d = tempo_q; swp_d = swp_q; oct_d = oct_q;
    tie_d = tie_q; lvl_d = lvl_q; acc_d = acc_q; err_d = err_q;
    pitch_d = pitch_q; ovol_d = ovol_q; osus_d = osus_q; oswp_d = oswp_q;
    oinst_d = oinst_q;
    ltab_we = 1'b0; tgt_we = 1'b0; cnt_we = 1'b0; cnt_new = cnt_q[slot];
    start_def = 1'b0;
    dreq.start = 1'b0;
    dreq.dividend = 20'(ltab_q[dir_q[3:0]]) * 20'(MsPerTickNum);
    dreq.divisor = tempo_q;
    unique case (st_q)
      StIdle: begin
        if (in_acc && mode_e'(mode_i) == ModeStart) begin
          start_def = 1'b1;
          pos_d = address_i;
        end
        if (in_acc && mode_e'(mode_i) == ModeFetch) begin
          steps_d = 16'd0; tie_d = 1'b0; lvl_d = 1'b0; acc_d = 32'd0;
          err_d = ErrNone; pitch_d = 8'd0; ovol_d = 8'd0; osus_d = 8'd0;
          oswp_d = 8'd0; oinst_d = 10'd0;
        end
      end
      StFetch: begin
        if (steps_q >= limit_q) begin
          err_d = ErrSteps;
        end else if (!wait_q) begin
          wait_d = 1'b1;
        end else begin
          dir_d = rdata;
          steps_d = steps_q + 16'd1;
          pos_d = pos_q + 16'd1;
        end
      end
      StDecode: begin
        if (dir_q >= NoteBase) begin
          if (tempo_q == 8'd0) begin
            err_d = ErrTempo;
          end else begin
            dreq.start = 1'b1;
            if (!tie_q) begin
              ovol_d = vol_q; osus_d = sus_q; oswp_d = swp_q; oinst_d = InstrumentRst;
              pitch_d = (dir_q[7:4] == 4'd3) ? 8'd0
                      : {1'b0, oct_q, 3'd0} + {2'd0, oct_q, 2'd0} + {4'd0, dir_q[7:4]}
                        - 8'd3;
            end
          end
        end else if (dir_q >= OctaveBase) begin
          oct_d = dir_q[3:0];
        end else if (dir_q >= InstBase && dir_q < LoopBase) begin
          oct_d = oct_q;
        end else if (!wait_q) begin
          wait_d = 1'b1;
        end else begin
          pos_d = pos_q + 16'd1;
          if (dir_q >= LengthBase) begin
            ltab_we = 1'b1;
          end else if (dir_q >= LoopBase) begin
            if (rdata[7]) begin
              if (rdata[6:0] != 7'd0) begin
                cnt_we = 1'b1;
                cnt_new = (cnt_q[slot] == 8'hFF) ? 8'hFF : cnt_q[slot] + 8'd1;
              end
              if (!(rdata[6:0] != 7'd0 && {1'b0, rdata[6:0]} <= cnt_q[slot])) begin
                pos_d = tgt_q[slot];
              end
            end else begin
              tgt_we = 1'b1;
              cnt_we = 1'b1;
              cnt_new = 8'd0;
            end
          end else if (dir_q == DirTempo) begin
            tempo_d = rdata;
          end else if (dir_q == DirSustain) begin
            sus_d = rdata;
          end else if (dir_q == DirVolume) begin
            vol_d = rdata;
          end else begin
            swp_d = rdata;
          end
        end
      end
      StDiv: begin
        if (drsp.done) begin
          acc_d = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          if (drsp.quotient != 20'd0) lvl_d = 1'b1;
        end
      end
      StAdd: wait_d = 1'b1;
      StTie1: dir_d = rdata;
      StTie2: begin
        if (dir_q == DirTempo && rdata == 8'd0) begin
          pos_d = pos_q + 16'd2; tie_d = 1'b1; lvl_d = 1'b0;
        end
      end
      StOut: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      limit_q <= StepLimitRst;
      pos_q <= 16'd0;
      wait_q <= 1'b0;
      vol_q <= 8'd0; sus_q <= 8'd0; tempo_q <= TempoRst; swp_q <= 8'd0;
      oct_q <= OctaveRst;
      for (int i = 0; i < LoopSlots; i++) begin
        tgt_q[i] <= 16'd0; cnt_q[i] <= 8'd0;
      end
      for (int i = 0; i < LengthSlots; i++) begin
        ltab_q[i] <= 8'd0;
      end
    end else begin
      st_q <= st_d;
      wait_q <= wait_d;
      if (cfg_valid_i && cfg_ready_o) limit_q <= cfg_data_i;
      if (start_def) begin
        pos_q <= pos_d;
        vol_q <= 8'd0; sus_q <= 8'd0; tempo_q <= TempoRst; swp_q <= 8'd0;
        oct_q <= OctaveRst;
        for (int i = 0; i < LoopSlots; i++) begin
          tgt_q[i] <= 16'd0; cnt_q[i] <= 8'd0;
        end
        for (int i = 0; i < LengthSlots; i++) begin
          ltab_q[i] <= 8'd0;
        end
      end else begin
        pos_q <= pos_d;
        vol_q <= vol_d; sus_q <= sus_d; tempo_q <= tempo_d; swp_q <= swp_d;
        oct_q <= oct_d;
        if (ltab_we) ltab_q[dir_q[3:0]] <= rdata;
        if (tgt_we) tgt_q[slot] <= pos_q + 16'd1 + {8'd0, rdata} - 16'd2;
        if (cnt_we) cnt_q[slot] <= cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    steps_q <= steps_d; dir_q <= dir_d; tie_q <= tie_d; lvl_q <= lvl_d;
    acc_q <= acc_d; err_q <= err_d; pitch_q <= pitch_d; ovol_q <= ovol_d;
    osus_q <= osus_d; oswp_q <= oswp_d; oinst_q <= oinst_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
    end else if (res_load) begin
      rvalid_q <= 1'b1;
    end else if (out_ready_i) begin
      rvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      rerr_q <= err_q;
      if (err_q == ErrNone) begin
        rpitch_q <= pitch_q; rvol_q <= ovol_q; rinst_q <= oinst_q;
        rsus_q <= osus_q; rswp_q <= oswp_q; rlen_q <= acc_q;
      end else begin
        rpitch_q <= 8'd0; rvol_q <= 8'd0; rinst_q <= 10'd0;
        rsus_q <= 8'd0; rswp_q <= 8'd0; rlen_q <= 32'd0;
      end
    end
  end

  always_comb begin
    out_valid_o = rvalid_q;
    pitch_o = rpitch_q; note_volume_o = rvol_q; note_instrument_o = rinst_q;
    note_sustain_o = rsus_q; note_sweep_o = rswp_q; length_ms_o = rlen_q;
    error_o = rerr_q;
  end

endmodule

// ===== verif/mbns_note_checker.sv =====
// ---------------------------------------------------------------------------
// Note sequencer checker
// Watches the configuration, item and note channels of the sequencer, keeps
// its own copy of the player state and song memory, predicts the note of
// every fetch beat and compares each note beat field by field.
// ---------------------------------------------------------------------------
module mbns_note_checker
  import mbns_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  mode_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  pitch_i,
  input  logic [7:0]  note_volume_i,
  input  logic [9:0]  note_instrument_i,
  input  logic [7:0]  note_sustain_i,
  input  logic [7:0]  note_sweep_i,
  input  logic [31:0] length_ms_i,
  input  logic [1:0]  error_i,
  output int          fails_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  pitch;
    logic [7:0]  vol;
    logic [9:0]  inst;
    logic [7:0]  sus;
    logic [7:0]  swp;
    logic [31:0] len;
    logic [1:0]  err;
  } note_t;

  logic [7:0]  song [0:65535];
  logic [15:0] play_pos;
  logic [15:0] loop_dest [LoopSlots];
  logic [7:0]  loop_cnt [LoopSlots];
  logic [7:0]  len_tab [LengthSlots];
  logic [7:0]  vol_q, sus_q, tempo_q, swp_q;
  logic [9:0]  inst_q;
  logic [3:0]  octave_q;
  logic [15:0] step_limit_q;
  note_t       notes_due [$];
  int          fails;

  assign fails_o = fails;
  assign pending_o = notes_due.size();

  task automatic player_home(input logic [15:0] start);
    play_pos = start;
    for (int i = 0; i < LoopSlots; i++) begin
      loop_dest[i] = '0;
      loop_cnt[i] = '0;
    end
    for (int i = 0; i < LengthSlots; i++) len_tab[i] = '0;
    vol_q = '0;
    inst_q = InstrumentRst;
    sus_q = '0;
    tempo_q = TempoRst;
    swp_q = '0;
    octave_q = OctaveRst;
  endtask

  task automatic play_note(output note_t r);
    int unsigned steps;
    logic [31:0] acc, len;
    logic [32:0] sum;
    logic [7:0]  b, opnd;
    logic [2:0]  slot;
    bit          in_tie, heard, stay;
    r = '0;
    acc = '0;
    steps = 0;
    in_tie = 0;
    heard = 0;
    forever begin
      if (steps >= step_limit_q) begin
        r = '0;
        r.err = ErrSteps;
        return;
      end
      steps++;
      b = song[play_pos];
      play_pos = play_pos + 16'd1;
      if (b >= NoteBase) begin
        if (tempo_q == 8'd0) begin
          r = '0;
          r.err = ErrTempo;
          return;
        end
        len = (32'(len_tab[b[3:0]]) * 32'd1500) / 32'(tempo_q);
        if (!in_tie) begin
          r.vol = vol_q;
          r.inst = inst_q;
          r.sus = sus_q;
          r.swp = swp_q;
          r.pitch = (b[7:4] == 4'd3) ? 8'd0 :
                    8'(octave_q) * 8'd12 + 8'(b[7:4]) - 8'd3;
        end
        sum = {1'b0, acc} + {1'b0, len};
        acc = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        if (len != 0) heard = 1;
        if (song[play_pos] == DirTempo && song[16'(play_pos + 16'd1)] == 8'h00) begin
          play_pos = play_pos + 16'd2;
          in_tie = 1;
          heard = 0;
          continue;
        end
        if (heard) break;
      end else if (b >= OctaveBase) begin
        octave_q = b[3:0];
      end else if (b >= LengthBase) begin
        len_tab[b[3:0]] = song[play_pos];
        play_pos = play_pos + 16'd1;
      end else if (b >= LoopBase) begin
        slot = b[2:0];
        opnd = song[play_pos];
        play_pos = play_pos + 16'd1;
        if (opnd[7]) begin
          stay = 0;
          if (opnd[6:0] != 7'd0) begin
            stay = 8'(opnd[6:0]) <= loop_cnt[slot];
            if (loop_cnt[slot] != 8'hFF) loop_cnt[slot] = loop_cnt[slot] + 8'd1;
          end
          if (!stay) play_pos = loop_dest[slot];
        end else begin
          loop_dest[slot] = play_pos + 16'(opnd) - 16'd2;
          loop_cnt[slot] = '0;
        end
      end else if (b == DirTempo) begin
        tempo_q = song[play_pos];
        play_pos = play_pos + 16'd1;
      end else if (b == DirSustain) begin
        sus_q = song[play_pos];
        play_pos = play_pos + 16'd1;
      end else if (b == DirVolume) begin
        vol_q = song[play_pos];
        play_pos = play_pos + 16'd1;
      end else if (b == DirSweep) begin
        swp_q = song[play_pos];
        play_pos = play_pos + 16'd1;
      end
    end
    r.len = acc;
    r.err = ErrNone;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR at %0t: %s got %0h, expected %0h", $realtime, what, got, want);
    fails++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    note_t want, fresh;
    if (!rst_ni) begin
      player_home(16'd0);
      step_limit_q = StepLimitRst;
      notes_due.delete();
      fails = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (notes_due.size() == 0) begin
          report_mismatch("note beat with none due, pitch", 32'(pitch_i), 32'd0);
        end else begin
          want = notes_due.pop_front();
          check_field("pitch", 32'(pitch_i), 32'(want.pitch));
          check_field("volume", 32'(note_volume_i), 32'(want.vol));
          check_field("instrument", 32'(note_instrument_i), 32'(want.inst));
          check_field("sustain", 32'(note_sustain_i), 32'(want.sus));
          check_field("sweep", 32'(note_sweep_i), 32'(want.swp));
          check_field("length", length_ms_i, want.len);
          check_field("error", 32'(error_i), 32'(want.err));
        end
      end
      if (cfg_valid_i && cfg_ready_i) step_limit_q = cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        case (mode_e'(mode_i))
          ModeLoad: begin
            song[address_i] = data_i;
          end
          ModeStart: begin
            player_home(address_i);
          end
          ModeFetch: begin
            play_note(fresh);
            notes_due.push_back(fresh);
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// ---------------------------------------------------------------------------
// Note sequencer testbench
// Loads songs into the sequencer, starts and fetches notes under several
// step budgets with random gaps and back-pressure, and lets the checker
// compare every note beat against its own prediction.
// ---------------------------------------------------------------------------
module tb_top;
  import mbns_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SongArea = 64;
  localparam int TailBytes = 140;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode = ModeNone;
  logic [15:0] address = '0;
  logic [7:0]  data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  pitch, note_volume, note_sustain, note_sweep;
  logic [9:0]  note_instrument;
  logic [31:0] length_ms;
  logic [1:0]  error;
  int          fails, pending;
  int          items_sent = 0;
  bit          calm = 0;
  int          stall_reqs = 0;
  int          stall_seen = 0;
  int          hold = 0;

  always #6 clk_i = ~clk_i;

  music_bytecode_note_sequencer u_dut (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .mode_i(mode), .address_i(address), .data_i(data),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .pitch_o(pitch), .note_volume_o(note_volume), .note_instrument_o(note_instrument),
    .note_sustain_o(note_sustain), .note_sweep_o(note_sweep),
    .length_ms_o(length_ms), .error_o(error)
  );

  mbns_note_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .mode_i(mode), .address_i(address), .data_i(data),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .pitch_i(pitch), .note_volume_i(note_volume), .note_instrument_i(note_instrument),
    .note_sustain_i(note_sustain), .note_sweep_i(note_sweep),
    .length_ms_i(length_ms), .error_i(error),
    .fails_o(fails), .pending_o(pending)
  );

  always @(negedge clk_i) begin
    if (stall_reqs != stall_seen) begin
      stall_seen = stall_reqs;
      hold = 300;
    end
    if (hold > 0) begin
      hold = hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 24);
    end
  end

  initial begin
    #2s;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_item(input mode_e m, input logic [15:0] a, input logic [7:0] d);
    @(negedge clk_i);
    if (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    mode <= m;
    address <= a;
    data <= d;
    @(posedge clk_i iff in_ready);
    items_sent++;
  endtask

  task automatic drain_notes();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [15:0] v);
    drain_notes();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i iff cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_bytes(input logic [15:0] base, input logic [7:0] q [$]);
    foreach (q[i]) send_item(ModeLoad, base + 16'(i), q[i]);
  endtask

  // Builds mostly well-formed directive runs with random content.
  task automatic make_song(input bit loops_ok, input int len, output logic [7:0] q [$]);
    int pick;
    q.delete();
    while (q.size() < len) begin
      pick = $urandom_range(99);
      if (pick < 35 || (pick >= 60 && pick < 70 && !loops_ok) || pick >= 90) begin
        q.push_back(8'($urandom_range(8'h30, 8'hFF)));
        if ($urandom_range(99) < 15) begin
          q.push_back(DirTempo);
          q.push_back(8'h00);
        end
      end else if (pick < 45) begin
        q.push_back(OctaveBase | 8'($urandom_range(15)));
      end else if (pick < 60) begin
        q.push_back(LengthBase | 8'($urandom_range(15)));
        q.push_back(8'($urandom_range(255)));
      end else if (pick < 70) begin
        q.push_back(LoopBase | 8'($urandom_range(7)));
        if ($urandom_range(1)) begin
          q.push_back(8'h80 | ($urandom_range(9) == 0 ? 8'h7F : 8'($urandom_range(4))));
        end else begin
          q.push_back(8'($urandom_range(24)));
        end
      end else if (pick < 85) begin
        q.push_back(8'($urandom_range(3)));
        if (q[q.size()-1] == DirTempo) begin
          q.push_back($urandom_range(9) == 0 ? 8'($urandom_range(1)) :
                      8'($urandom_range(40, 255)));
        end else begin
          q.push_back(8'($urandom_range(255)));
        end
      end else begin
        q.push_back(8'($urandom_range(4, 7)));
      end
    end
    while (q.size() > len) void'(q.pop_back());
  endtask

  initial begin
    logic [7:0] song_q [$];
    logic [7:0] tail_q [$];
    logic [7:0] gen_q [$];
    int phase, fetches;
    bit whole;
    song_q = '{8'h01, 8'hFF, 8'h02, 8'h80, 8'h00, 8'h7F, 8'h05, 8'h11, 8'h0C, 8'h2F,
               8'hF1, 8'h03, 8'h00, 8'h32, 8'h31, 8'h20, 8'h33, 8'h31, 8'h1F, 8'hFF,
               8'h03, 8'hFF, 8'h4F, 8'h03, 8'h01, 8'h4F, 8'h05, 8'h03, 8'h00, 8'h4F,
               8'h03, 8'h78, 8'h0A, 8'h03, 8'h05, 8'h21, 8'h0A, 8'h82, 8'h41, 8'h09,
               8'h80};
    tail_q.delete();
    // Every fetch that runs past the song area ends inside this pattern,
    // whatever the byte alignment, so no unwritten byte is ever read.
    for (int i = 0; i < TailBytes / 7; i++) begin
      tail_q.push_back(8'h11);
      tail_q.push_back(8'h11);
      tail_q.push_back(8'h11);
      repeat (4) tail_q.push_back(8'h31);
    end
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    make_song(1'b1, SongArea - song_q.size(), gen_q);
    load_bytes(16'd0, song_q);
    load_bytes(16'(song_q.size()), gen_q);
    load_bytes(16'(SongArea), tail_q);
    send_item(ModeStart, 16'd0, 8'h00);
    repeat (6) send_item(ModeFetch, 16'hFFFF, 8'hFF);
    send_item(ModeNone, 16'hFFFF, 8'hFF);
    repeat (2) send_item(ModeFetch, 16'd0, 8'h00);
    load_bytes(16'hFFFC, '{8'h11, 8'h40, 8'h2A, 8'h35});
    send_item(ModeStart, 16'hFFFC, 8'h00);
    send_item(ModeFetch, 16'd0, 8'h00);
    write_limit(16'd0);
    send_item(ModeFetch, 16'd0, 8'h00);
    write_limit(16'd1);
    send_item(ModeStart, 16'd0, 8'h00);
    repeat (2) send_item(ModeFetch, 16'd0, 8'h00);
    write_limit(16'hFFFF);
    load_bytes(16'd0, '{8'h03, 8'h01, 8'h1F, 8'hFF, 8'h0C, 8'h02, 8'h0B, 8'h02, 8'h4F,
                        8'h03, 8'h00, 8'h0B, 8'hFF, 8'h0C, 8'hFF, 8'h4F, 8'h05, 8'h05});
    send_item(ModeStart, 16'd0, 8'h00);
    send_item(ModeFetch, 16'd0, 8'h00);

    phase = 0;
    while (items_sent < 1250) begin
      calm = (phase >= 10 && phase < 16);
      if (phase == 4) begin
        write_limit(16'hFFFF);
      end else begin
        case ($urandom_range(9))
          0: write_limit(16'($urandom_range(1, 8)));
          1: write_limit(StepLimitRst);
          default: write_limit(16'($urandom_range(1, 400)));
        endcase
      end
      whole = (phase == 4) || $urandom_range(1);
      if (whole) begin
        make_song(phase != 4, SongArea, gen_q);
        load_bytes(16'd0, gen_q);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_item(ModeLoad, 16'($urandom_range(SongArea - 1)), 8'($urandom_range(255)));
        end
      end
      repeat ($urandom_range(3)) begin
        send_item(ModeLoad, 16'($urandom_range(256, 16'hFFEF)), 8'($urandom_range(255)));
      end
      if ($urandom_range(7) == 0) send_item(ModeNone, 16'($urandom_range(16'hFFFF)),
                                            8'($urandom_range(255)));
      send_item(ModeStart, 16'($urandom_range(SongArea - 1)), 8'($urandom_range(255)));
      if (phase == 2 || $urandom_range(19) == 0) stall_reqs++;
      fetches = $urandom_range(4, 16);
      repeat (fetches) begin
        if ($urandom_range(9) == 0) begin
          send_item(ModeLoad, 16'($urandom_range(256, 16'hFFEF)), 8'($urandom_range(255)));
        end
        send_item(ModeFetch, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)));
      end
      phase++;
    end
    calm = 0;

    drain_notes();
    repeat (100) @(negedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
